### hw/rtl/bmmg_pkg.sv
// shared types, widths and constants of the beat and measure marker generator
`timescale 1ns / 1ps
`default_nettype none

package bmmg_pkg;

    // field widths
    localparam int TIME_W  = 32;
    localparam int NBT_W   = 40;
    localparam int TRK_W   = 6;
    localparam int SIG_W   = 8;
    localparam int CPB_W   = 16;
    localparam int MEAS_W  = 16;
    localparam int LEN_W   = CPB_W + 2;
    localparam int CNT_W   = TIME_W + 1;

    // shared divider: dividend is left-aligned in DIV_W bits
    localparam int DIV_W   = NBT_W;
    localparam int ITER_W  = $clog2(DIV_W + 1);

    // marker limit per event and the counter that walks it
    localparam int MAX_MARKERS = 63;
    localparam int LEFT_W      = $clog2(MAX_MARKERS + 1);

    localparam logic [CPB_W-1:0]  CPB_RESET   = CPB_W'(96);
    localparam logic [SIG_W-1:0]  SIG_DEFAULT = SIG_W'(4);
    localparam logic [MEAS_W-1:0] MEAS_MAX    = {MEAS_W{1'b1}};

    // input operation codes
    localparam logic OP_EVENT  = 1'b0;
    localparam logic OP_REWIND = 1'b1;

    // result kinds
    localparam logic KIND_MARKER = 1'b0;
    localparam logic KIND_EVENT  = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN_GO,
        S_LEN_WAIT,
        S_CNT_GO,
        S_CNT_WAIT,
        S_MARK,
        S_MUL,
        S_BULK,
        S_BDIV_WAIT,
        S_EVT
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [LEN_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } t_div_req;

    // response from the shared divider
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [LEN_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

### hw/rtl/beat_measure_marker_generator.sv
// top level of the beat and measure marker generator
//
// channel  direction  request                  fields
// s_axis   in         timed event or rewind    tdata, tuser
// m_axis   out        beat marker or event     tdata, tuser, tlast
// cfg      in         clocks per beat write    i_cfg_wdata
//
// a timed event goes through the beat length divide, the beat count divide
// (only when a beat is due), one marker a cycle while m_axis accepts (at most 63),
// the multiply and beat divide when beats beyond the marker limit are folded in
// (the divide only with a nonzero numerator) and then the event result;
// all divides go one bit a cycle through the one shared divider
// a rewind is handled in the idle state and gives no result
// reset is synchronous; no clearing pass is needed
// a stall on m_axis holds the sequencer at the marker or event being sent
`timescale 1ns / 1ps
`default_nettype none

module beat_measure_marker_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    // events in
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // event_time, track, sig_numerator, sig_denominator, zero pad
    input  wire logic [55:0] i_s_axis_tdata,
    // op, is_time_signature
    input  wire logic [1:0]  i_s_axis_tuser,
    // results out
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // time_res, track_out, beat, measure, bar_start, markers_dropped
    output logic [63:0]      o_m_axis_tdata,
    // kind
    output logic [0:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);
    import bmmg_pkg::*;

    // state registers
    t_state              r_state, n_state;
    logic [CPB_W-1:0]    r_cpb, n_cpb;
    logic [NBT_W-1:0]    r_nbt, n_nbt;
    logic [SIG_W-1:0]    r_beat, n_beat;
    logic [MEAS_W-1:0]   r_meas, n_meas;
    logic [SIG_W-1:0]    r_sig_num, n_sig_num;
    logic [SIG_W-1:0]    r_sig_den, n_sig_den;

    // per-event working registers
    logic [TIME_W-1:0]   r_t, n_t;
    logic [TRK_W-1:0]    r_trk, n_trk;
    logic                r_is_sig, n_is_sig;
    logic [SIG_W-1:0]    r_num, n_num;
    logic [SIG_W-1:0]    r_den, n_den;
    logic [LEN_W-1:0]    r_step, n_step;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic [TIME_W+LEN_W-1:0] r_prod, n_prod;
    logic                r_drop, n_drop;

    // output register
    logic                r_ov, n_ov;
    logic                r_o_kind, n_o_kind;
    logic [TIME_W-1:0]   r_o_time, n_o_time;
    logic [TRK_W-1:0]    r_o_trk, n_o_trk;
    logic [SIG_W-1:0]    r_o_beat, n_o_beat;
    logic [MEAS_W-1:0]   r_o_meas, n_o_meas;
    logic                r_o_nm, n_o_nm;
    logic                r_o_drop, n_o_drop;
    logic                r_o_last, n_o_last;

    // divider link
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    // helpers
    logic                w_in_fire;
    logic                w_out_free;
    logic                w_mark_fire;
    logic [SIG_W-1:0]    w_den_eff;
    logic [NBT_W-1:0]    w_gap;
    logic                w_due;
    logic [SIG_W:0]      w_beat_inc;
    logic                w_wrap;
    logic [CNT_W-1:0]    w_rest_full;
    logic [TIME_W-1:0]   w_rest;
    logic                w_wrap_first;
    logic [SIG_W-1:0]    w_b0;
    logic [TIME_W-1:0]   w_r1;
    logic [CNT_W-1:0]    w_total;
    logic [CNT_W:0]      w_meas_sum;
    logic [CNT_W-1:0]    w_meas_rest;

    bmmg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // handshakes
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_ov || i_m_axis_tready;
    assign w_mark_fire     = (r_state == S_MARK) && w_out_free;

    // shared arithmetic terms
    always_comb begin
        w_den_eff    = (r_sig_den == '0) ? SIG_W'(1) : r_sig_den;
        w_gap        = {{(NBT_W-TIME_W){1'b0}}, r_t} - r_nbt;
        w_due        = r_nbt <= {{(NBT_W-TIME_W){1'b0}}, r_t};
        w_beat_inc   = {1'b0, r_beat} + (SIG_W+1)'(1);
        w_wrap       = (r_sig_num == '0) || (w_beat_inc >= {1'b0, r_sig_num});
        w_rest_full  = r_n - CNT_W'(MAX_MARKERS);
        w_rest       = w_rest_full[TIME_W-1:0];
        w_wrap_first = r_beat >= r_sig_num;
        w_b0         = w_wrap_first ? '0 : r_beat;
        w_r1         = w_wrap_first ? (w_rest - TIME_W'(1)) : w_rest;
        w_total      = {{(CNT_W-SIG_W){1'b0}}, w_b0} + {1'b0, w_r1};
        w_meas_sum   = {{(CNT_W+1-MEAS_W){1'b0}}, r_meas}
                     + {{CNT_W{1'b0}}, w_wrap_first}
                     + {1'b0, w_div_rsp.quot[CNT_W-1:0]};
        w_meas_rest  = {{(CNT_W-MEAS_W){1'b0}}, r_meas} + {1'b0, w_rest};
    end

    // sequencer: next state, working registers and output register
    always_comb begin
        n_state   = r_state;
        n_cpb     = r_cpb;
        n_nbt     = r_nbt;
        n_beat    = r_beat;
        n_meas    = r_meas;
        n_sig_num = r_sig_num;
        n_sig_den = r_sig_den;
        n_t       = r_t;
        n_trk     = r_trk;
        n_is_sig  = r_is_sig;
        n_num     = r_num;
        n_den     = r_den;
        n_step    = r_step;
        n_n       = r_n;
        n_left    = r_left;
        n_prod    = r_prod;
        n_drop    = r_drop;
        n_ov      = r_ov && !i_m_axis_tready;
        n_o_kind  = r_o_kind;
        n_o_time  = r_o_time;
        n_o_trk   = r_o_trk;
        n_o_beat  = r_o_beat;
        n_o_meas  = r_o_meas;
        n_o_nm    = r_o_nm;
        n_o_drop  = r_o_drop;
        n_o_last  = r_o_last;

        w_div_req.start    = 1'b0;
        w_div_req.dividend = '0;
        w_div_req.divisor  = '0;
        w_div_req.iters    = '0;

        // clocks per beat; the user must write it only while idle, the block does not enforce this
        if (i_cfg_we) begin
            n_cpb = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_s_axis_tuser[0] == OP_REWIND) begin
                        // back to time zero in 4/4
                        n_sig_num = SIG_DEFAULT;
                        n_sig_den = SIG_DEFAULT;
                        n_beat    = '0;
                        n_meas    = '0;
                        n_nbt     = {{(NBT_W-CPB_W){1'b0}},
                                     (r_cpb == '0) ? CPB_W'(1) : r_cpb};
                    end else begin
                        n_t      = i_s_axis_tdata[31:0];
                        n_trk    = i_s_axis_tdata[37:32];
                        n_num    = i_s_axis_tdata[45:38];
                        n_den    = i_s_axis_tdata[53:46];
                        n_is_sig = i_s_axis_tuser[1];
                        n_drop   = 1'b0;
                        n_state  = S_LEN_GO;
                    end
                end
            end
            S_LEN_GO: begin
                // beat length = clocks_per_beat * 4 / denominator
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {r_cpb, 2'b00, {(DIV_W-LEN_W){1'b0}}};
                w_div_req.divisor  = {{(LEN_W-SIG_W){1'b0}}, w_den_eff};
                w_div_req.iters    = ITER_W'(LEN_W);
                n_state            = S_LEN_WAIT;
            end
            S_LEN_WAIT: begin
                if (w_div_rsp.done) begin
                    n_step  = (w_div_rsp.quot[LEN_W-1:0] == '0) ? LEN_W'(1)
                                                                : w_div_rsp.quot[LEN_W-1:0];
                    n_state = w_due ? S_CNT_GO : S_EVT;
                end
            end
            S_CNT_GO: begin
                // beats due = (event time - next beat time) / length + 1
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {w_gap[TIME_W-1:0], {(DIV_W-TIME_W){1'b0}}};
                w_div_req.divisor  = r_step;
                w_div_req.iters    = ITER_W'(TIME_W);
                n_state            = S_CNT_WAIT;
            end
            S_CNT_WAIT: begin
                if (w_div_rsp.done) begin
                    n_n     = {1'b0, w_div_rsp.quot[TIME_W-1:0]} + CNT_W'(1);
                    n_left  = (n_n > CNT_W'(MAX_MARKERS)) ? LEFT_W'(MAX_MARKERS)
                                                          : n_n[LEFT_W-1:0];
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                // one marker a cycle while the output register is free
                if (w_out_free) begin
                    n_beat   = w_wrap ? '0 : w_beat_inc[SIG_W-1:0];
                    n_meas   = (w_wrap && r_meas != MEAS_MAX) ? r_meas + MEAS_W'(1)
                                                              : r_meas;
                    n_nbt    = r_nbt + {{(NBT_W-LEN_W){1'b0}}, r_step};
                    n_ov     = 1'b1;
                    n_o_kind = KIND_MARKER;
                    n_o_time = r_nbt[TIME_W-1:0];
                    n_o_trk  = '0;
                    n_o_beat = n_beat;
                    n_o_meas = n_meas;
                    n_o_nm   = w_wrap;
                    n_o_drop = 1'b0;
                    n_o_last = 1'b0;
                    n_left   = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_state = (r_n > CNT_W'(MAX_MARKERS)) ? S_MUL : S_EVT;
                    end
                end
            end
            S_MUL: begin
                // time span of the beats beyond the limit
                n_prod  = w_rest * r_step;
                n_state = S_BULK;
            end
            S_BULK: begin
                n_nbt  = r_nbt + r_prod[NBT_W-1:0];
                n_drop = 1'b1;
                if (r_sig_num == '0) begin
                    n_beat  = '0;
                    n_meas  = (w_meas_rest > CNT_W'(MEAS_MAX)) ? MEAS_MAX
                                                               : w_meas_rest[MEAS_W-1:0];
                    n_state = S_EVT;
                end else begin
                    // fold skipped beats into beat and measure
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = {w_total, {(DIV_W-CNT_W){1'b0}}};
                    w_div_req.divisor  = {{(LEN_W-SIG_W){1'b0}}, r_sig_num};
                    w_div_req.iters    = ITER_W'(CNT_W);
                    n_state            = S_BDIV_WAIT;
                end
            end
            S_BDIV_WAIT: begin
                if (w_div_rsp.done) begin
                    n_beat  = w_div_rsp.rem[SIG_W-1:0];
                    n_meas  = (w_meas_sum > (CNT_W+1)'(MEAS_MAX)) ? MEAS_MAX
                                                                  : w_meas_sum[MEAS_W-1:0];
                    n_state = S_EVT;
                end
            end
            S_EVT: begin
                // the event itself, then a possible signature change
                if (w_out_free) begin
                    n_ov     = 1'b1;
                    n_o_kind = KIND_EVENT;
                    n_o_time = r_t;
                    n_o_trk  = r_trk;
                    n_o_beat = r_beat;
                    n_o_meas = r_meas;
                    n_o_nm   = 1'b0;
                    n_o_drop = r_drop;
                    n_o_last = 1'b1;
                    if (r_is_sig && r_trk == '0) begin
                        n_sig_num = r_num;
                        n_sig_den = r_den;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cpb     <= CPB_RESET;
            r_nbt     <= {{(NBT_W-CPB_W){1'b0}}, CPB_RESET};
            r_beat    <= '0;
            r_meas    <= '0;
            r_sig_num <= SIG_DEFAULT;
            r_sig_den <= SIG_DEFAULT;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cpb     <= n_cpb;
            r_nbt     <= n_nbt;
            r_beat    <= n_beat;
            r_meas    <= n_meas;
            r_sig_num <= n_sig_num;
            r_sig_den <= n_sig_den;
            r_ov      <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_trk    <= n_trk;
        r_is_sig <= n_is_sig;
        r_num    <= n_num;
        r_den    <= n_den;
        r_step   <= n_step;
        r_n      <= n_n;
        r_left   <= n_left;
        r_prod   <= n_prod;
        r_drop   <= n_drop;
        r_o_kind <= n_o_kind;
        r_o_time <= n_o_time;
        r_o_trk  <= n_o_trk;
        r_o_beat <= n_o_beat;
        r_o_meas <= n_o_meas;
        r_o_nm   <= n_o_nm;
        r_o_drop <= n_o_drop;
        r_o_last <= n_o_last;
    end

    // result port
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_o_drop, r_o_nm, r_o_meas, r_o_beat, r_o_trk, r_o_time};
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;

    // divider is never restarted mid-division
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    // beat stays inside the measure after each marker
    a_beat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mark_fire |=> (r_beat == '0) || (r_beat < r_sig_num))
        else $error("beat beyond numerator after marker");

    // a timed event keeps the input closed while it is worked on
    a_busy_after_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_s_axis_tuser[0] == OP_EVENT) |=> !o_s_axis_tready)
        else $error("input reopened during event");

endmodule

`default_nettype wire

### hw/rtl/bmmg_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module bmmg_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bmmg_pkg::t_div_req i_req,
    output bmmg_pkg::t_div_rsp      o_rsp
);
    import bmmg_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_W-1:0]  r_q;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_dvs;
    logic [ITER_W-1:0] r_cnt;

    logic [LEN_W:0]    w_trial;
    logic [LEN_W:0]    w_diff;
    logic              w_fits;

    // trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        w_trial = {r_rem, r_q[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_fits  = !w_diff[LEN_W];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == ITER_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_cnt <= i_req.iters;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[LEN_W-1:0] : w_trial[LEN_W-1:0];
            r_cnt <= r_cnt - ITER_W'(1);
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire
